// ===== sv/pse_pkg.sv =====
// shared types, codes and constants of the postfix stack evaluator
package pse_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int FRAC_BITS = 16;
   localparam int OPERAND_W = 32;
   localparam int VAL_W = OPERAND_W + FRAC_BITS;
   localparam int CMD_W = 3;
   localparam int STATUS_W = 3;
   localparam int MUL_STEPS = VAL_W;
   localparam int DIV_STEPS = VAL_W + FRAC_BITS;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_SUB   = 3'd2,
      CMD_MUL   = 3'd3,
      CMD_DIV   = 3'd4,
      CMD_CLEAR = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_DIV_ZERO  = 3'd1,
      STAT_UNDERFLOW = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      logic                    start;
      cmd_type                 op;
      logic signed [VAL_W-1:0] lhs;
      logic signed [VAL_W-1:0] rhs;
   } arith_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [VAL_W-1:0] result;
      logic                    sat;
   } arith_rsp_type;

endpackage

// ===== sv/pse_stack_ram.sv =====
// stack storage: one write port, one registered read port
module pse_stack_ram #(
   parameter int DEPTH  = pse_pkg::STACK_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic signed [pse_pkg::VAL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic signed [pse_pkg::VAL_W-1:0] rd_data
);
   import pse_pkg::*;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pse_arith.sv =====
// iterative fixed-point arithmetic unit around one shared adder
module pse_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  pse_pkg::arith_req_type req,
   output pse_pkg::arith_rsp_type rsp
);
   import pse_pkg::*;

   localparam int ADD_W = VAL_W + 2;
   localparam int MAG_W = VAL_W + VAL_W - FRAC_BITS;

   typedef enum logic [1:0] {
      A_IDLE,
      A_SETUP,
      A_ITER,
      A_FINISH
   } arith_state_type;

   arith_state_type         state_ff;
   cmd_type                 op_ff;
   logic signed [VAL_W-1:0] lhs_ff;
   logic signed [VAL_W-1:0] rhs_ff;
   logic                    neg_ff;
   logic [VAL_W-1:0]        ma_ff;
   logic [VAL_W-1:0]        hi_ff;
   logic [DIV_STEPS-1:0]    lo_ff;
   logic [STEP_CNT_W-1:0]   count_ff;
   logic                    done_ff;
   logic signed [VAL_W-1:0] result_ff;
   logic                    sat_ff;

   logic [ADD_W-1:0]        add_a;
   logic [ADD_W-1:0]        add_b;
   logic                    add_cin;
   logic [ADD_W-1:0]        add_sum;
   logic [VAL_W:0]          shifted;
   logic                    ge;
   logic [VAL_W-1:0]        mag_l;
   logic [VAL_W-1:0]        mag_r;
   logic [MAG_W-1:0]        mag;
   logic                    mag_ge_lim;
   logic                    mag_eq_lim;
   logic [STEP_CNT_W-1:0]   last_step;
   logic signed [VAL_W-1:0] clamp_val;
   logic                    clamp_sat;
   logic signed [VAL_W-1:0] fin_val;
   logic                    fin_sat;

   assign mag_l = lhs_ff[VAL_W-1] ? VAL_W'(~lhs_ff + 1'b1) : VAL_W'(lhs_ff);
   assign mag_r = rhs_ff[VAL_W-1] ? VAL_W'(~rhs_ff + 1'b1) : VAL_W'(rhs_ff);

   // divider trial: partial remainder shifted left by one quotient bit
   assign shifted = {hi_ff, lo_ff[DIV_STEPS-1]};

   // shared adder
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         A_SETUP: begin
            add_a = {{2{lhs_ff[VAL_W-1]}}, lhs_ff};
            if (op_ff == CMD_SUB) begin
               add_b   = ~{{2{rhs_ff[VAL_W-1]}}, rhs_ff};
               add_cin = 1'b1;
            end else begin
               add_b = {{2{rhs_ff[VAL_W-1]}}, rhs_ff};
            end
         end
         A_ITER: begin
            if (op_ff == CMD_MUL) begin
               add_a = {2'b00, hi_ff};
               add_b = lo_ff[0] ? {2'b00, ma_ff} : '0;
            end else begin
               add_a   = {1'b0, shifted};
               add_b   = ~{2'b00, ma_ff};
               add_cin = 1'b1;
            end
         end
         default: begin
         end
      endcase
      add_sum = add_a + add_b + ADD_W'(add_cin);
   end

   assign ge = ~add_sum[ADD_W-1];

   // add and subtract overflow shows as disagreement of the top two bits
   always_comb begin
      clamp_sat = add_sum[VAL_W] != add_sum[VAL_W-1];
      if (clamp_sat) begin
         clamp_val = add_sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         clamp_val = add_sum[VAL_W-1:0];
      end
   end

   // apply sign to the magnitude and saturate
   always_comb begin
      if (op_ff == CMD_MUL) begin
         mag = {hi_ff, lo_ff[VAL_W-1:FRAC_BITS]};
      end else begin
         mag = MAG_W'(lo_ff);
      end
      mag_ge_lim = |mag[MAG_W-1:VAL_W-1];
      mag_eq_lim = mag[VAL_W-1] && !(|mag[MAG_W-1:VAL_W]) && !(|mag[VAL_W-2:0]);
      if (neg_ff) begin
         if (mag_ge_lim) begin
            fin_val = VAL_MIN;
            fin_sat = !mag_eq_lim;
         end else begin
            fin_val = VAL_W'(~mag[VAL_W-1:0] + 1'b1);
            fin_sat = 1'b0;
         end
      end else begin
         fin_sat = mag_ge_lim;
         fin_val = mag_ge_lim ? VAL_MAX : mag[VAL_W-1:0];
      end
   end

   assign last_step = (op_ff == CMD_MUL) ? STEP_CNT_W'(MUL_STEPS - 1)
                                         : STEP_CNT_W'(DIV_STEPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (req.start) begin
                  op_ff    <= req.op;
                  lhs_ff   <= req.lhs;
                  rhs_ff   <= req.rhs;
                  state_ff <= A_SETUP;
               end
            end
            A_SETUP: begin
               neg_ff   <= lhs_ff[VAL_W-1] ^ rhs_ff[VAL_W-1];
               count_ff <= '0;
               hi_ff    <= '0;
               unique case (op_ff)
                  CMD_ADD, CMD_SUB: begin
                     result_ff <= clamp_val;
                     sat_ff    <= clamp_sat;
                     done_ff   <= 1'b1;
                     state_ff  <= A_IDLE;
                  end
                  CMD_MUL: begin
                     ma_ff    <= mag_l;
                     lo_ff    <= DIV_STEPS'(mag_r);
                     state_ff <= A_ITER;
                  end
                  CMD_DIV: begin
                     ma_ff    <= mag_r;
                     lo_ff    <= {mag_l, {FRAC_BITS{1'b0}}};
                     state_ff <= A_ITER;
                  end
                  default: begin
                     result_ff <= '0;
                     sat_ff    <= 1'b0;
                     done_ff   <= 1'b1;
                     state_ff  <= A_IDLE;
                  end
               endcase
            end
            A_ITER: begin
               if (op_ff == CMD_MUL) begin
                  // shift-add: one multiplier bit per cycle
                  hi_ff <= add_sum[VAL_W:1];
                  lo_ff <= DIV_STEPS'({add_sum[0], lo_ff[VAL_W-1:1]});
               end else begin
                  // restoring divide: one quotient bit per cycle
                  hi_ff <= ge ? add_sum[VAL_W-1:0] : shifted[VAL_W-1:0];
                  lo_ff <= {lo_ff[DIV_STEPS-2:0], ge};
               end
               count_ff <= count_ff + 1'b1;
               if (count_ff == last_step) begin
                  state_ff <= A_FINISH;
               end
            end
            A_FINISH: begin
               result_ff <= fin_val;
               sat_ff    <= fin_sat;
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;
   assign rsp.sat    = sat_ff;

endmodule

// ===== sv/postfix_stack_evaluator.sv =====
// postfix stack evaluator: one token at a time on a bounded Q32.16 stack
// push, clear and error tokens are answered from the decode state; add, subtract,
// multiply and divide go on through the fetch and calc states to the arithmetic unit
// one token at a time; busy stays high until the result strobe, the shared
// adder in the arithmetic unit takes one multiplier or quotient bit per cycle
// the result is shown for exactly one cycle; the receiver cannot stall
// synchronous reset empties the stack; stack storage is not cleared
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT,
   parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pse_pkg::CMD_W-1:0]         req_command,
   input  logic signed [pse_pkg::OPERAND_W-1:0] req_operand_value,
   output logic                              rsp_valid,
   output logic signed [pse_pkg::VAL_W-1:0]  rsp_top_value,
   output logic [DEPTH_W-1:0]                rsp_stack_depth,
   output logic [pse_pkg::STATUS_W-1:0]      rsp_status
);
   import pse_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_CALC
   } state_type;

   state_type                 state_ff, state_in;
   logic [DEPTH_W-1:0]        sp_ff, sp_in;
   logic signed [VAL_W-1:0]   top_ff, top_in;
   cmd_type                   cmd_ff;
   logic signed [OPERAND_W-1:0] operand_ff;
   logic                      rsp_valid_ff;
   logic signed [VAL_W-1:0]   rsp_top_ff;
   logic [DEPTH_W-1:0]        rsp_depth_ff;
   status_type                rsp_status_ff;
   status_type                status_in;
   logic                      finish;

   logic [DEPTH_W-1:0]        sp_m2;
   logic signed [VAL_W-1:0]   push_value;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VAL_W-1:0]   wr_data;
   logic signed [VAL_W-1:0]   rd_data;
   arith_req_type             arith_req;
   arith_rsp_type             arith_rsp;

   assign sp_m2      = sp_ff - DEPTH_W'(2);
   assign push_value = {operand_ff, {FRAC_BITS{1'b0}}};

   pse_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (sp_m2[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   pse_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arith_req),
      .rsp   (arith_rsp)
   );

   // top_ff mirrors the entry below sp_ff, so only the left operand is read
   always_comb begin
      state_in        = state_ff;
      sp_in           = sp_ff;
      top_in          = top_ff;
      status_in       = STAT_OK;
      finish          = 1'b0;
      wr_en           = 1'b0;
      wr_addr         = sp_ff[ADDR_W-1:0];
      wr_data         = push_value;
      arith_req.start = 1'b0;
      arith_req.op    = cmd_ff;
      arith_req.lhs   = rd_data;
      arith_req.rhs   = top_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            finish   = 1'b1;
            state_in = S_IDLE;
            unique case (cmd_ff)
               CMD_PUSH: begin
                  if (sp_ff == DEPTH_W'(STACK_DEPTH)) begin
                     status_in = STAT_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     sp_in  = sp_ff + 1'b1;
                     top_in = push_value;
                  end
               end
               CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                  if (sp_ff < DEPTH_W'(2)) begin
                     status_in = STAT_UNDERFLOW;
                  end else if (cmd_ff == CMD_DIV && top_ff == '0) begin
                     status_in = STAT_DIV_ZERO;
                  end else begin
                     finish   = 1'b0;
                     state_in = S_FETCH;
                  end
               end
               CMD_CLEAR: begin
                  sp_in  = '0;
                  top_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_FETCH: begin
            arith_req.start = 1'b1;
            state_in        = S_CALC;
         end
         S_CALC: begin
            if (arith_rsp.done) begin
               wr_en     = 1'b1;
               wr_addr   = sp_m2[ADDR_W-1:0];
               wr_data   = arith_rsp.result;
               sp_in     = sp_ff - 1'b1;
               top_in    = arith_rsp.result;
               status_in = arith_rsp.sat ? STAT_SATURATED : STAT_OK;
               finish    = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         top_ff       <= top_in;
         rsp_valid_ff <= finish;
         if (state_ff == S_IDLE && start) begin
            cmd_ff     <= cmd_type'(req_command);
            operand_ff <= req_operand_value;
         end
         if (finish) begin
            rsp_top_ff    <= top_in;
            rsp_depth_ff  <= sp_in;
            rsp_status_ff <= status_in;
         end
      end
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== sv/pse_checker.sv =====
// port-level checks of the postfix stack evaluator and their binding
module pse_checker #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT,
   parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic signed [pse_pkg::VAL_W-1:0] rsp_top_value,
   input logic [DEPTH_W-1:0]               rsp_stack_depth,
   input logic [pse_pkg::STATUS_W-1:0]     rsp_status
);
   import pse_pkg::*;

   // an accepted token keeps the block busy in the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a token transfer");

   // a result strobe lasts one cycle
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // the result comes out as the block turns free
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stack_depth <= DEPTH_W'(STACK_DEPTH))
      else $error("reported depth beyond stack size");

   // an empty stack reads as zero with no arithmetic status
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stack_depth == '0) |->
         (rsp_top_value == '0 && rsp_status != STAT_SATURATED))
      else $error("empty stack with nonzero top or saturation");

endmodule

bind postfix_stack_evaluator pse_checker #(
   .STACK_DEPTH (STACK_DEPTH),
   .DEPTH_W     (DEPTH_W)
) u_pse_checker (.*);

// ===== sim/tb_postfix_stack_evaluator.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the postfix stack evaluator: directed tokens, then random expressions
module tb_postfix_stack_evaluator;
   import pse_pkg::*;

   localparam int LIFO_DEPTH    = STACK_DEPTH_DEFAULT;
   localparam int DEPTH_W       = $clog2(LIFO_DEPTH + 1);
   localparam int RANDOM_TOKENS = 1300;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam int WIDE_W        = 2 * VAL_W;

   // codes the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   typedef logic signed [VAL_W-1:0] fixed_type;
   typedef logic [WIDE_W-1:0] wide_mag_type;

   localparam wide_mag_type NEG_BOUND = wide_mag_type'(1) << (VAL_W - 1);

   typedef struct packed {
      fixed_type           top;
      logic [DEPTH_W-1:0]  depth;
      status_type          status;
   } stack_view_type;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [OPERAND_W-1:0] operand;
      logic                 typed;
      stack_view_type       view;
   } token_row_type;

   localparam stack_view_type NO_VIEW = '{top: '0, depth: '0, status: STAT_OK};

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [CMD_W-1:0]             req_command;
   logic signed [OPERAND_W-1:0]  req_operand_value;
   logic                         rsp_valid;
   logic signed [VAL_W-1:0]      rsp_top_value;
   logic [DEPTH_W-1:0]           rsp_stack_depth;
   logic [STATUS_W-1:0]          rsp_status;

   fixed_type      stack_image [LIFO_DEPTH];
   int             stack_level = 0;
   stack_view_type expected_views [$];
   int             failures = 0;
   int             cycle_count = 0;
   int             tokens_sent = 0;
   int             status_tally [8] = '{default: 0};
   int             steady_left = 0;
   int             fill_left = 0;

   // rows without a typed view are checked against the predictor
   token_row_type directed_rows [26] = '{
      '{CMD_ADD,    32'h0,         1'b1, '{48'h0,              7'd0, STAT_UNDERFLOW}},
      '{CMD_PUSH,   32'h7FFF_FFFF, 1'b1, '{48'h7FFF_FFFF_0000, 7'd1, STAT_OK}},
      '{CMD_DIV,    32'h0,         1'b1, '{48'h7FFF_FFFF_0000, 7'd1, STAT_UNDERFLOW}},
      '{CMD_PUSH,   32'h8000_0000, 1'b1, '{48'h8000_0000_0000, 7'd2, STAT_OK}},
      '{CMD_SUB,    32'h0,         1'b1, '{48'h7FFF_FFFF_FFFF, 7'd1, STAT_SATURATED}},
      '{CMD_PUSH,   32'h0,         1'b1, '{48'h0,              7'd2, STAT_OK}},
      '{CMD_DIV,    32'h0,         1'b1, '{48'h0,              7'd2, STAT_DIV_ZERO}},
      '{CMD_MUL,    32'h0,         1'b1, '{48'h0,              7'd1, STAT_OK}},
      '{CMD_PUSH,   32'hFFFF_FFFF, 1'b1, '{48'hFFFF_FFFF_0000, 7'd2, STAT_OK}},
      '{CMD_PUSH,   32'h3,         1'b1, '{48'h0000_0003_0000, 7'd3, STAT_OK}},
      '{CMD_DIV,    32'h0,         1'b0, NO_VIEW},
      '{CMD_SUB,    32'h0,         1'b0, NO_VIEW},
      '{CMD_CLEAR,  32'h0,         1'b1, '{48'h0,              7'd0, STAT_OK}},
      '{CMD_SPARE6, 32'h1234_5678, 1'b1, '{48'h0,              7'd0, STAT_OK}},
      '{CMD_SPARE7, 32'hFFFF_FFFF, 1'b1, '{48'h0,              7'd0, STAT_OK}},
      '{CMD_PUSH,   32'h8000_0000, 1'b1, '{48'h8000_0000_0000, 7'd1, STAT_OK}},
      '{CMD_PUSH,   32'h8000_0000, 1'b1, '{48'h8000_0000_0000, 7'd2, STAT_OK}},
      '{CMD_MUL,    32'h0,         1'b1, '{48'h7FFF_FFFF_FFFF, 7'd1, STAT_SATURATED}},
      '{CMD_PUSH,   32'h8000_0000, 1'b1, '{48'h8000_0000_0000, 7'd2, STAT_OK}},
      '{CMD_PUSH,   32'h7FFF_FFFF, 1'b1, '{48'h7FFF_FFFF_0000, 7'd3, STAT_OK}},
      '{CMD_MUL,    32'h0,         1'b1, '{48'h8000_0000_0000, 7'd2, STAT_SATURATED}},
      '{CMD_PUSH,   32'hFFFF_FFFF, 1'b1, '{48'hFFFF_FFFF_0000, 7'd3, STAT_OK}},
      '{CMD_DIV,    32'h0,         1'b1, '{48'h7FFF_FFFF_FFFF, 7'd2, STAT_SATURATED}},
      '{CMD_ADD,    32'h0,         1'b1, '{48'h7FFF_FFFF_FFFF, 7'd1, STAT_SATURATED}},
      '{CMD_PUSH,   32'h5A5A_5A5A, 1'b1, '{48'h5A5A_5A5A_0000, 7'd2, STAT_OK}},
      '{CMD_MUL,    32'h0,         1'b0, NO_VIEW}
   };

   postfix_stack_evaluator #(
      .STACK_DEPTH(LIFO_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_top_value     (rsp_top_value),
      .rsp_stack_depth   (rsp_stack_depth),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic wide_mag_type magnitude_of(fixed_type v);
      logic [VAL_W-1:0] m;
      m = v[VAL_W-1] ? ~v + 1'b1 : v;
      return wide_mag_type'(m);
   endfunction

   function automatic fixed_type signed_clip(wide_mag_type mag, logic neg,
                                             output logic clipped);
      clipped = 1'b0;
      if (neg) begin
         if (mag >= NEG_BOUND) begin
            // exactly the negative bound fits without clipping
            clipped = (mag > NEG_BOUND);
            return VAL_MIN;
         end
         return ~mag[VAL_W-1:0] + 1'b1;
      end
      if (mag >= NEG_BOUND) begin
         clipped = 1'b1;
         return VAL_MAX;
      end
      return mag[VAL_W-1:0];
   endfunction

   // applies one token to the predicted stack and returns what the block should report
   function automatic stack_view_type evaluate_token(logic [CMD_W-1:0] cmd,
                                                     logic [OPERAND_W-1:0] operand);
      stack_view_type         v;
      fixed_type              lhs;
      fixed_type              rhs;
      fixed_type              res;
      logic signed [VAL_W:0]  sum;
      wide_mag_type           ma;
      wide_mag_type           mb;
      logic                   clipped;
      v.status = STAT_OK;
      clipped = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (stack_level >= LIFO_DEPTH) begin
               v.status = STAT_FULL;
            end else begin
               stack_image[stack_level] = {operand, {FRAC_BITS{1'b0}}};
               stack_level++;
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (stack_level < 2) begin
               v.status = STAT_UNDERFLOW;
            end else begin
               rhs = stack_image[stack_level-1];
               lhs = stack_image[stack_level-2];
               if (cmd == CMD_DIV && rhs == 0) begin
                  v.status = STAT_DIV_ZERO;
               end else begin
                  ma = magnitude_of(lhs);
                  mb = magnitude_of(rhs);
                  if (cmd == CMD_ADD || cmd == CMD_SUB) begin
                     sum = (cmd == CMD_ADD) ? lhs + rhs : lhs - rhs;
                     if (sum[VAL_W] != sum[VAL_W-1]) begin
                        clipped = 1'b1;
                        res = sum[VAL_W] ? VAL_MIN : VAL_MAX;
                     end else begin
                        res = sum[VAL_W-1:0];
                     end
                  end else if (cmd == CMD_MUL) begin
                     res = signed_clip((ma * mb) >> FRAC_BITS, lhs[VAL_W-1] ^ rhs[VAL_W-1],
                                       clipped);
                  end else begin
                     res = signed_clip((ma << FRAC_BITS) / mb, lhs[VAL_W-1] ^ rhs[VAL_W-1],
                                       clipped);
                  end
                  stack_image[stack_level-2] = res;
                  stack_level--;
                  if (clipped) v.status = STAT_SATURATED;
               end
            end
         end
         CMD_CLEAR: begin
            stack_level = 0;
         end
         default: begin
         end
      endcase
      v.depth = DEPTH_W'(stack_level);
      if (stack_level > 0) v.top = stack_image[stack_level-1];
      else v.top = '0;
      return v;
   endfunction

   function automatic logic [OPERAND_W-1:0] draw_operand();
      case ($urandom_range(9))
         0: return '0;
         1: return $urandom_range(16) - 8;
         2, 3: return $urandom_range(2000) - 1000;
         4: return $urandom_range(65535) - 32768;
         5: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h1;
               default: return '1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // sender gap, with runs of back-to-back tokens now and then
   function automatic int draw_gap();
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      if ($urandom_range(29) == 0) begin
         steady_left = $urandom_range(40, 10);
         return 0;
      end
      return $urandom_range(9);
   endfunction

   task automatic issue_token(input logic [CMD_W-1:0] cmd, input logic [OPERAND_W-1:0] operand,
                              input int gap, input logic typed,
                              input stack_view_type typed_view);
      stack_view_type view;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_operand_value <= operand;
      do @(posedge clock); while (busy);
      // transfer taken at this edge
      view = evaluate_token(cmd, operand);
      if (typed) view = typed_view;
      status_tally[view.status]++;
      tokens_sent++;
      expected_views.push_back(view);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      stack_view_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_views.size() == 0) begin
            $display("%0t: unexpected result: top %h depth %0d status %0d", $time,
                     rsp_top_value, rsp_stack_depth, rsp_status);
            failures++;
         end else begin
            want = expected_views.pop_front();
            if (rsp_top_value !== want.top) begin
               $display("%0t: top_value expected %h actual %h", $time, want.top,
                        rsp_top_value);
               failures++;
            end
            if (rsp_stack_depth !== want.depth) begin
               $display("%0t: stack_depth expected %0d actual %0d", $time, want.depth,
                        rsp_stack_depth);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_views.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [CMD_W-1:0] cmd;
      int               roll;
      int               issued;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_PUSH;
      req_operand_value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_token(directed_rows[i].cmd, directed_rows[i].operand, draw_gap(),
                     directed_rows[i].typed, directed_rows[i].view);
      wait_drained();

      issued = 0;
      while (issued < RANDOM_TOKENS) begin
         roll = $urandom_range(199);
         if (fill_left > 0) begin
            cmd = CMD_PUSH;
            fill_left--;
         end else if (roll == 0) begin
            // push until the stack is full and a little past it
            fill_left = LIFO_DEPTH - stack_level + $urandom_range(3);
            cmd = CMD_PUSH;
         end else if (roll < 16) begin
            cmd = CMD_W'($urandom_range(7));
         end else if (roll < 20) begin
            cmd = CMD_CLEAR;
         end else if (stack_level < 2 || (roll < 110 && stack_level < LIFO_DEPTH)) begin
            cmd = CMD_PUSH;
         end else begin
            cmd = CMD_W'($urandom_range(CMD_DIV, CMD_ADD));
         end
         issue_token(cmd, draw_operand(), draw_gap(), 1'b0, NO_VIEW);
         if (cmd != CMD_SPARE6 && cmd != CMD_SPARE7) begin
            issued++;
            if (issued % 300 == 0) wait_drained();
         end
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d tokens: %0d ok, %0d zero divisors, %0d underflows,", tokens_sent,
               status_tally[STAT_OK], status_tally[STAT_DIV_ZERO],
               status_tally[STAT_UNDERFLOW]);
      $display("%0d pushes onto a full stack, %0d saturated results, %0d mismatches",
               status_tally[STAT_FULL], status_tally[STAT_SATURATED], failures);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
